// ----- design/lir_pkg.sv -----
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and fixed constants for the linear interpolating resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  // Width of one I or Q sample.
  localparam int SAMPLE_W = 16;

  // Fractional bits of the interpolation weight and its rounding offset.
  localparam int FRAC_BITS = 15;
  localparam int ONE_Q15   = 32768;
  localparam int ROUND_Q15 = 16384;

  // One input word: a complex sample.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_i;
    logic signed [SAMPLE_W-1:0] in_q;
  } in_word_t;

  // One output word: an interpolated complex sample.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
  } out_word_t;

endpackage

// ----- design/linear_interp_resampler.sv -----
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Rational-ratio I/Q resampler with linear interpolation between samples.
// ----------------------------------------------------------------------------
// The block takes one complex sample per clock while in_stall is low, and gives
// out OUT_BLOCK output words for every IN_BLOCK input words. Output j sits at
// input position j*IN_BLOCK/OUT_BLOCK. It is registered into the output buffer
// when the sample that follows its base position is taken, as prev +
// frac*(cur - prev) with a Q15 weight and round-half-up. At most one word comes
// out per input word; when IN_BLOCK < OUT_BLOCK any further outputs that fall
// on the same input are dropped while the phase still advances. The sustained
// rate is one input word per clock while the output is not stalled. The input
// port feeds the phase and interpolation logic directly, and the output
// register is the only stage. The output side has a two-word buffer, so the
// input is stalled only when both words are held by a stalled downstream.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
  parameter int IN_BLOCK  = 3072,
  parameter int OUT_BLOCK = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lir_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output lir_pkg::out_word_t out_word
);

  import lir_pkg::*;

  // Phase is kept as the distance from the previous input to the next output,
  // in units of 1/OUT_BLOCK of an input period. Once an output has been made
  // it stays below IN_BLOCK; just after reset it equals OUT_BLOCK.
  localparam int OM    = OUT_BLOCK % IN_BLOCK;
  localparam int GMAX  = (OUT_BLOCK > IN_BLOCK - 1) ? OUT_BLOCK : IN_BLOCK - 1;
  localparam int G_W   = $clog2(GMAX + 1);
  localparam int FMAX  = (GMAX * ONE_Q15) / OUT_BLOCK;
  localparam int F_W   = $clog2(FMAX + 1);
  localparam int R_W   = $clog2(OUT_BLOCK);

  // Step taken after an output when the phase is at least OM: minus OM.
  localparam int B_NUM = (OM * ONE_Q15) / OUT_BLOCK;
  localparam int B_MOD = (OM * ONE_Q15) % OUT_BLOCK;
  localparam int QBN   = (B_MOD == 0) ? B_NUM : B_NUM + 1;
  localparam int RB    = (B_MOD == 0) ? 0 : OUT_BLOCK - B_MOD;

  // Step taken after an output when the phase is below OM: plus IN_BLOCK-OM.
  localparam int CC    = IN_BLOCK - OM;
  localparam int QC    = (CC * ONE_Q15) / OUT_BLOCK;
  localparam int RC    = (CC * ONE_Q15) % OUT_BLOCK;

  // State registers.
  logic [G_W-1:0]              pos;
  logic [F_W-1:0]              frac;
  logic [R_W-1:0]              frac_rem;
  logic signed [SAMPLE_W-1:0]  prev_i;
  logic signed [SAMPLE_W-1:0]  prev_q;

  logic [G_W-1:0]              pos_next;
  logic [F_W-1:0]              frac_next;
  logic [R_W-1:0]              frac_rem_next;

  // Output buffer: the visible word and one skid word.
  out_word_t                   skid_word;
  logic                        skid_valid;

  logic                        in_fire;
  logic                        out_take;
  logic                        emit;
  logic                        pos_hi;
  logic [R_W:0]                rem_sum;
  logic                        rem_carry;
  out_word_t                   result;

  logic signed [FRAC_BITS:0]   weight;
  logic signed [SAMPLE_W:0]    diff_i;
  logic signed [SAMPLE_W:0]    diff_q;
  logic signed [32:0]          prod_i;
  logic signed [32:0]          prod_q;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // An output is due when the next output lies within this input period.
  assign emit   = (frac < F_W'(ONE_Q15));
  assign pos_hi = (pos >= G_W'(OM));

  // Phase and interpolation weight for the next input word.
  always_comb begin
    rem_sum       = '0;
    rem_carry     = 1'b0;
    pos_next      = pos;
    frac_next     = frac;
    frac_rem_next = frac_rem;
    if (!emit) begin
      pos_next  = pos - G_W'(OUT_BLOCK);
      frac_next = frac - F_W'(ONE_Q15);
    end else if (pos_hi) begin
      rem_sum       = {1'b0, frac_rem} + (R_W + 1)'(RB);
      rem_carry     = (rem_sum >= (R_W + 1)'(OUT_BLOCK));
      pos_next      = pos - G_W'(OM);
      frac_next     = frac - F_W'(QBN) + F_W'(rem_carry);
      frac_rem_next = rem_carry ? R_W'(rem_sum - (R_W + 1)'(OUT_BLOCK))
                                : rem_sum[R_W-1:0];
    end else begin
      rem_sum       = {1'b0, frac_rem} + (R_W + 1)'(RC);
      rem_carry     = (rem_sum >= (R_W + 1)'(OUT_BLOCK));
      pos_next      = pos + G_W'(CC);
      frac_next     = frac + F_W'(QC) + F_W'(rem_carry);
      frac_rem_next = rem_carry ? R_W'(rem_sum - (R_W + 1)'(OUT_BLOCK))
                                : rem_sum[R_W-1:0];
    end
  end

  // Linear interpolation with round-half-up on the Q15 product.
  always_comb begin
    weight       = $signed({1'b0, frac[FRAC_BITS-1:0]});
    diff_i       = {in_word.in_i[SAMPLE_W-1], in_word.in_i} - {prev_i[SAMPLE_W-1], prev_i};
    diff_q       = {in_word.in_q[SAMPLE_W-1], in_word.in_q} - {prev_q[SAMPLE_W-1], prev_q};
    prod_i       = 33'(weight) * 33'(diff_i) + 33'(ROUND_Q15);
    prod_q       = 33'(weight) * 33'(diff_q) + 33'(ROUND_Q15);
    result.out_i = prev_i + prod_i[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
    result.out_q = prev_q + prod_q[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
  end

  // Phase state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= G_W'(OUT_BLOCK);
      frac     <= F_W'(ONE_Q15);
      frac_rem <= '0;
      prev_i   <= '0;
      prev_q   <= '0;
    end else if (in_fire) begin
      pos      <= pos_next;
      frac     <= frac_next;
      frac_rem <= frac_rem_next;
      prev_i   <= in_word.in_i;
      prev_q   <= in_word.in_q;
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire && emit) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Output buffer data.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_word <= skid_word;
      end
    end else if (in_fire && emit) begin
      if (out_valid && !out_take) begin
        skid_word <= result;
      end else begin
        out_word <= result;
      end
    end
  end

endmodule

// ----- design/lir_checker.sv -----
// ----------------------------------------------------------------------------
// lir_checker
// Port-level checks for the linear interpolating resampler.
// ----------------------------------------------------------------------------
module lir_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input lir_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input lir_pkg::out_word_t out_word
);

  import lir_pkg::*;

  // A stalled input word must stay offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed or dropped while stalled");

  // A stalled output word must stay offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed or dropped while stalled");

  // A new output word only follows an accepted input word.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("output word appeared without an accepted input word");

  // The input is held back only while a stalled output word is pending.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("input stalled without a stalled output word");

  // Nothing is offered straight after reset.
  assert property (@(posedge clk)
    $fell(rst) |-> !out_valid && !in_stall)
    else $error("output buffer not empty after reset");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);

// ----- verif/tb_linear_interp_resampler.sv -----
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler
// Self-checking testbench for the linear interpolating I/Q resampler.
// ----------------------------------------------------------------------------
// A queue of complex samples feeds a clocked driver. The queue holds a short
// directed run of full-scale swings and rounding ties, followed by random
// words. A clocked monitor keeps a predictor of the 3:2 phase accumulator and
// of the Q15 interpolation. It checks every output word, field by field,
// against the oldest prediction. Both ports idle at random. Each side has a
// stretch without gaps, and the receiver holds off once for long enough to
// back the block up into its input.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler;
  timeunit 1ns;
  timeprecision 1ps;

  import lir_pkg::*;

  localparam int IN_RATIO       = 3072;
  localparam int OUT_RATIO      = 2048;
  localparam int RANDOM_WORDS   = 1330;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // Samples waiting to be offered, and interpolated words still to arrive.
  in_word_t  samples_to_send[$];
  out_word_t expected_words[$];

  // Predictor state: last sample, phase remainder and input countdown.
  int last_i     = 0;
  int last_q     = 0;
  int phase_r    = 0;
  int inputs_due = 2;

  int errors      = 0;
  int words_in    = 0;
  int words_out   = 0;
  int stall_seen  = 0;
  int sent_cnt    = 0;
  int rx_cnt      = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int quiet_count = 0;

  linear_interp_resampler #(
    .IN_BLOCK (IN_RATIO),
    .OUT_BLOCK(OUT_RATIO)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Interpolates between two samples with a Q15 weight, rounding half up.
  function automatic logic signed [SAMPLE_W-1:0] interpolate(input int a, input int b,
                                                             input longint weight);
    longint prod;
    prod = weight * (longint'(b) - longint'(a)) + ROUND_Q15;
    return SAMPLE_W'(a + int'(prod >>> FRAC_BITS));
  endfunction

  // Advances the phase accumulator by one input sample and queues any output.
  task automatic resample_step(input in_word_t w);
    longint    weight;
    int        total;
    out_word_t y;
    if (inputs_due > 0) inputs_due--;
    if (inputs_due == 0) begin
      weight  = (longint'(phase_r) * ONE_Q15) / OUT_RATIO;
      y.out_i = interpolate(last_i, w.in_i, weight);
      y.out_q = interpolate(last_q, w.in_q, weight);
      expected_words.push_back(y);
      // Outputs landing on the same input are skipped; their phase still counts.
      total = phase_r + IN_RATIO;
      while (total < OUT_RATIO) total += IN_RATIO;
      inputs_due = total / OUT_RATIO;
      phase_r    = total % OUT_RATIO;
    end
    last_i = w.in_i;
    last_q = w.in_q;
  endtask

  task automatic queue_sample(input int i, input int q);
    in_word_t w;
    w.in_i = SAMPLE_W'(i);
    w.in_q = SAMPLE_W'(q);
    samples_to_send.push_back(w);
  endtask

  // Driver: may offer the next sample when the current word has gone or none is up; gaps are random outside calm spans.
  always @(posedge clk) begin
    bit gaps_on;
    gaps_on = !(sent_cnt >= 500 && sent_cnt < 800) && hold_left == 0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (samples_to_send.size() != 0 && !(gaps_on && $urandom_range(99) < 31)) begin
        in_valid <= 1'b1;
        in_word  <= samples_to_send.pop_front();
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) rx_cnt++;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && rx_cnt >= 150) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (rx_cnt >= 400 && rx_cnt < 650) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 31);
      end
    end
  end

  // Monitor: predicts from accepted inputs first, then checks the output word.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        resample_step(in_word);
        words_in++;
      end
      if (in_stall) stall_seen++;
      if (out_valid && !out_stall) begin
        words_out++;
        if (expected_words.size() == 0) begin
          $error("output word 0x%08h arrived with nothing expected", out_word);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_word.out_i !== want.out_i) begin
            $error("out_i: expected %0d, got %0d", want.out_i, out_word.out_i);
            errors++;
          end
          if (out_word.out_q !== want.out_q) begin
            $error("out_q: expected %0d, got %0d", want.out_q, out_word.out_q);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run if neither port moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    int pick;
    int prev_i;
    int prev_q;

    // Full-scale swings, zero, and odd steps that hit the half-way rounding tie.
    queue_sample(0, 0);
    queue_sample(32767, -32768);
    queue_sample(-32768, 32767);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(32767, -32768);
    queue_sample(0, 0);
    queue_sample(1, -1);
    queue_sample(0, 0);
    queue_sample(-1, 1);
    queue_sample(2, -3);
    queue_sample(-1, 0);
    queue_sample(0, -1);
    queue_sample(-3, 2);
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    queue_sample(-32767, 32766);
    queue_sample(32766, -32767);
    queue_sample(5, -5);
    queue_sample(-32768, -32768);
    queue_sample(32767, 32767);
    queue_sample(-32768, 0);

    // Random part: full-range words, slow ramps around the last word, and extremes.
    prev_i = 0;
    prev_q = 0;
    repeat (RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        prev_i = $urandom_range(65535);
        prev_q = $urandom_range(65535);
      end else if (pick < 85) begin
        prev_i = prev_i + $urandom_range(64) - 32;
        prev_q = prev_q + $urandom_range(64) - 32;
      end else begin
        prev_i = $urandom_range(1) ? 32767 : -32768;
        prev_q = $urandom_range(1) ? 32767 : -32768;
      end
      queue_sample(prev_i, prev_q);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: every sample taken, every prediction matched, then a short tail.
    while (samples_to_send.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Resampled %0d input words into %0d output words at %0d:%0d.",
             words_in, words_out, IN_RATIO, OUT_RATIO);
    $display("Input was held back on %0d cycles, including one long output hold-off.",
             stall_seen);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
